FILE: sv/salcs_pkg.sv
// ----------------------------------------------------------------------------
// salcs_pkg
// Shared codes and field widths for the suffix automaton LCS engine.
// ----------------------------------------------------------------------------
package salcs_pkg;

    typedef enum logic [1:0] {
        MODE_CLEAR   = 2'd0,
        MODE_EXTEND  = 2'd1,
        MODE_RESTART = 2'd2,
        MODE_MATCH   = 2'd3
    } mode_t;

    localparam int MODE_W   = 2;
    localparam int SYM_W    = 8;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 48;
    localparam int POS_W    = 16;

endpackage

FILE: sv/suffix_automaton_lcs_engine_core.sv
// ----------------------------------------------------------------------------
// Steps: clear sweeps the root row; restart resets the matcher; match walks suffix
// links until a transition is found; extend sweeps the new row and walks states,
// and on a clone copies the row of q and redirects states to the clone.
// One item at a time; a new item is taken while the last result waits.
// Reset: control state cleared, then a sweep over every symbol empties the root
// row, with s_tready low.
// ----------------------------------------------------------------------------
// suffix_automaton_lcs_engine_core
// Builds a suffix automaton from text beats and matches pattern beats
// against it, reporting the longest common substring length and end.
// ----------------------------------------------------------------------------
module suffix_automaton_lcs_engine_core
    import salcs_pkg::*;
#(
    parameter int MAX_TEXT    = 256,
    parameter int SYMBOL_BITS = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // mode[1:0], symbol[9:2]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata   // status[0], states_used[9:1],
                                          // match_length[18:10], best_length[27:19],
                                          // best_end[43:28]
);

    localparam int NSTATES = 2 * MAX_TEXT;
    localparam int ALPHA   = 1 << SYMBOL_BITS;
    localparam int SB      = $clog2(NSTATES);
    localparam int LB      = $clog2(MAX_TEXT + 1);
    localparam int CB      = $clog2(NSTATES + 1);
    localparam int AB      = SYMBOL_BITS;
    localparam int TRB     = SB + AB;
    localparam int NW      = LB + SB;

    typedef enum logic [3:0] {
        S_IDLE, S_SWEEP, S_W_RD, S_W_EV, S_Q_RD, S_Q_EV, S_COPY,
        S_R_RD, S_R_EV, S_FIX_Q, S_FIX_CUR, S_M_RD, S_M_EV, S_FIN
    } state_t;

    // memories
    logic [SB-1:0] tr_mem [0:(1 << TRB)-1];
    logic [NW-1:0] node_mem [0:NSTATES-1];

    logic           tr_we, node_we;
    logic [TRB-1:0] tr_waddr, tr_raddr;
    logic [SB-1:0]  tr_wdata, tr_rdata;
    logic [SB-1:0]  node_waddr, node_raddr;
    logic [NW-1:0]  node_wdata, node_rdata;

    always_ff @(posedge aclk) begin
        if (tr_we) begin
            tr_mem[tr_waddr] <= tr_wdata;
        end
        tr_rdata <= tr_mem[tr_raddr];
    end

    always_ff @(posedge aclk) begin
        if (node_we) begin
            node_mem[node_waddr] <= node_wdata;
        end
        node_rdata <= node_mem[node_raddr];
    end

    logic [LB-1:0] nlen;
    logic [SB-1:0] nlink;
    assign nlen  = node_rdata[NW-1:SB];
    assign nlink = node_rdata[SB-1:0];

    state_t        state_reg;
    logic [AB:0]   cnt_reg;
    logic [SB-1:0] row_reg, p_reg, q_reg, cur_reg, cl_reg, last_reg, v_reg;
    logic [LB-1:0] cur_len_reg, last_len_reg, lenp_reg, lenq_reg, mlen_reg, best_reg;
    logic [CB-1:0] count_reg;
    logic [AB-1:0] sym_reg;
    logic [POS_W-1:0] pos_reg, best_pos_reg;
    logic          sweep_ext_reg, quiet_reg, pend_reg, stat_reg;
    logic          m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    logic [MODE_W-1:0] in_mode;
    logic [LB:0]   lenp_inc;
    logic [CB:0]   count_plus2;
    logic [LB-1:0] m_eff, m_new;
    logic          out_free;
    logic [31:0]   cnt32, mlen32, best32;

    assign in_mode     = s_tdata[MODE_W-1:0];
    assign lenp_inc    = (LB+1)'(lenp_reg) + (LB+1)'(1);
    assign count_plus2 = (CB+1)'(count_reg) + (CB+1)'(2);
    assign m_eff       = pend_reg ? nlen : mlen_reg;
    assign m_new       = (tr_rdata != '0) ? m_eff + LB'(1) : m_eff;
    assign out_free    = !m_tvalid_reg || m_tready;
    assign cnt32       = 32'(count_reg);
    assign mlen32      = 32'(mlen_reg);
    assign best32      = 32'(best_reg);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        tr_we      = 1'b0;
        tr_waddr   = {p_reg, sym_reg};
        tr_wdata   = '0;
        tr_raddr   = {p_reg, sym_reg};
        node_we    = 1'b0;
        node_waddr = cur_reg;
        node_wdata = {cur_len_reg, cl_reg};
        node_raddr = p_reg;
        case (state_reg)
            S_SWEEP: begin
                tr_we    = 1'b1;
                tr_waddr = {row_reg, cnt_reg[AB-1:0]};
                if (!sweep_ext_reg && cnt_reg == '0) begin
                    node_we    = 1'b1;
                    node_waddr = '0;
                    node_wdata = '0;
                end
            end
            S_W_EV: begin
                if (tr_rdata == '0) begin
                    tr_we    = 1'b1;
                    tr_wdata = cur_reg;
                    if (p_reg == '0) begin
                        node_we    = 1'b1;
                        node_wdata = {cur_len_reg, SB'(0)};
                    end
                end
            end
            S_Q_RD: node_raddr = q_reg;
            S_Q_EV: begin
                node_we = 1'b1;
                if (lenp_inc == (LB+1)'(nlen)) begin
                    node_wdata = {cur_len_reg, q_reg};
                end else begin
                    node_waddr = count_reg[SB-1:0];
                    node_wdata = {lenp_inc[LB-1:0], nlink};
                end
            end
            S_COPY: begin
                tr_raddr = {q_reg, cnt_reg[AB-1:0]};
                if (cnt_reg != '0) begin
                    tr_we    = 1'b1;
                    tr_waddr = {cl_reg, cnt_reg[AB-1:0] - AB'(1)};
                    tr_wdata = tr_rdata;
                end
            end
            S_R_EV: begin
                if (tr_rdata == q_reg) begin
                    tr_we    = 1'b1;
                    tr_wdata = cl_reg;
                end
            end
            S_FIX_Q: begin
                node_we    = 1'b1;
                node_waddr = q_reg;
                node_wdata = {lenq_reg, cl_reg};
            end
            S_FIX_CUR: node_we = 1'b1;
            S_M_RD: begin
                tr_raddr   = {v_reg, sym_reg};
                node_raddr = v_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_SWEEP;
            cnt_reg       <= '0;
            row_reg       <= '0;
            sweep_ext_reg <= 1'b0;
            quiet_reg     <= 1'b1;
            count_reg     <= CB'(1);
            last_reg      <= '0;
            last_len_reg  <= '0;
            v_reg         <= '0;
            mlen_reg      <= '0;
            best_reg      <= '0;
            best_pos_reg  <= '0;
            pos_reg       <= '0;
            pend_reg      <= 1'b0;
            stat_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != S_FIN) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        sym_reg  <= s_tdata[MODE_W +: AB];
                        stat_reg <= 1'b0;
                        cnt_reg  <= '0;
                        case (in_mode)
                            MODE_CLEAR: begin
                                count_reg     <= CB'(1);
                                last_reg      <= '0;
                                last_len_reg  <= '0;
                                row_reg       <= '0;
                                sweep_ext_reg <= 1'b0;
                                quiet_reg     <= 1'b0;
                                v_reg         <= '0;
                                mlen_reg      <= '0;
                                best_reg      <= '0;
                                best_pos_reg  <= '0;
                                pos_reg       <= '0;
                                state_reg     <= S_SWEEP;
                            end
                            MODE_EXTEND: begin
                                if (32'(last_len_reg) >= MAX_TEXT ||
                                    32'(count_plus2) > NSTATES) begin
                                    stat_reg  <= 1'b1;
                                    state_reg <= S_FIN;
                                end else begin
                                    cur_reg       <= count_reg[SB-1:0];
                                    row_reg       <= count_reg[SB-1:0];
                                    count_reg     <= count_reg + CB'(1);
                                    cur_len_reg   <= last_len_reg + LB'(1);
                                    p_reg         <= last_reg;
                                    sweep_ext_reg <= 1'b1;
                                    state_reg     <= S_SWEEP;
                                end
                            end
                            MODE_RESTART: begin
                                v_reg        <= '0;
                                mlen_reg     <= '0;
                                best_reg     <= '0;
                                best_pos_reg <= '0;
                                pos_reg      <= '0;
                                state_reg    <= S_FIN;
                            end
                            default: begin
                                pend_reg  <= 1'b0;
                                state_reg <= S_M_RD;
                            end
                        endcase
                    end
                end
                S_SWEEP: begin
                    cnt_reg <= cnt_reg + (AB+1)'(1);
                    if (cnt_reg[AB-1:0] == {AB{1'b1}}) begin
                        if (sweep_ext_reg) begin
                            state_reg <= S_W_RD;
                        end else if (quiet_reg) begin
                            quiet_reg <= 1'b0;
                            state_reg <= S_IDLE;
                        end else begin
                            state_reg <= S_FIN;
                        end
                    end
                end
                S_W_RD: state_reg <= S_W_EV;
                S_W_EV: begin
                    if (tr_rdata == '0) begin
                        if (p_reg == '0) begin
                            last_reg     <= cur_reg;
                            last_len_reg <= cur_len_reg;
                            state_reg    <= S_FIN;
                        end else begin
                            p_reg     <= nlink;
                            state_reg <= S_W_RD;
                        end
                    end else begin
                        q_reg     <= tr_rdata;
                        lenp_reg  <= nlen;
                        state_reg <= S_Q_RD;
                    end
                end
                S_Q_RD: state_reg <= S_Q_EV;
                S_Q_EV: begin
                    if (lenp_inc == (LB+1)'(nlen)) begin
                        last_reg     <= cur_reg;
                        last_len_reg <= cur_len_reg;
                        state_reg    <= S_FIN;
                    end else begin
                        cl_reg    <= count_reg[SB-1:0];
                        count_reg <= count_reg + CB'(1);
                        lenq_reg  <= nlen;
                        cnt_reg   <= '0;
                        state_reg <= S_COPY;
                    end
                end
                S_COPY: begin
                    cnt_reg <= cnt_reg + (AB+1)'(1);
                    if (cnt_reg == (AB+1)'(ALPHA)) begin
                        state_reg <= S_R_RD;
                    end
                end
                S_R_RD: state_reg <= S_R_EV;
                S_R_EV: begin
                    if (tr_rdata == q_reg && p_reg != '0) begin
                        p_reg     <= nlink;
                        state_reg <= S_R_RD;
                    end else begin
                        state_reg <= S_FIX_Q;
                    end
                end
                S_FIX_Q: state_reg <= S_FIX_CUR;
                S_FIX_CUR: begin
                    last_reg     <= cur_reg;
                    last_len_reg <= cur_len_reg;
                    state_reg    <= S_FIN;
                end
                S_M_RD: state_reg <= S_M_EV;
                S_M_EV: begin
                    if (v_reg != '0 && tr_rdata == '0) begin
                        v_reg     <= nlink;
                        mlen_reg  <= m_eff;
                        pend_reg  <= 1'b1;
                        state_reg <= S_M_RD;
                    end else begin
                        pend_reg <= 1'b0;
                        mlen_reg <= m_new;
                        if (tr_rdata != '0) begin
                            v_reg <= tr_rdata;
                        end
                        if (m_new > best_reg) begin
                            best_reg     <= m_new;
                            best_pos_reg <= pos_reg;
                        end
                        if (pos_reg != {POS_W{1'b1}}) begin
                            pos_reg <= pos_reg + POS_W'(1);
                        end
                        state_reg <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {4'd0, best_pos_reg, best32[8:0], mlen32[8:0],
                                         cnt32[8:0], stat_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: tb/suffix_automaton_lcs_engine_core_test.sv
// ----------------------------------------------------------------------------
// suffix_automaton_lcs_engine_core_test
// Drives text and pattern beats into the suffix automaton LCS engine and
// checks every result beat against a behavioural model of the automaton.
// ----------------------------------------------------------------------------
module suffix_automaton_lcs_engine_core_test;
    import salcs_pkg::*;

    localparam int MAXT    = 256;
    localparam int ALPHA   = 256;
    localparam int NST     = 2 * MAXT;
    localparam int POS_MAX = 65535;
    localparam int WDOG    = 20000;

    typedef struct packed {
        logic [15:0] best_end;
        logic [8:0]  best_len;
        logic [8:0]  match_len;
        logic [8:0]  states;
        logic        status;
    } lcs_res_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    suffix_automaton_lcs_engine_core dut (.*);

    always #5 aclk = ~aclk;

    // automaton model
    int trans [NST*ALPHA];
    int slen  [NST];
    int slink [NST];
    int n_states, last_st, m_state, cur_len, best_len, best_pos, pat_pos;

    lcs_res_t lcs_q[$];
    int       n_err = 0;
    int       idle_cyc = 0;
    bit       timed_out = 0;
    int       burst_left = 0;

    function automatic void matcher_restart();
        m_state = 0; cur_len = 0; best_len = 0; best_pos = 0; pat_pos = 0;
    endfunction

    function automatic void row_empty(int s);
        for (int i = 0; i < ALPHA; i++) trans[s*ALPHA+i] = 0;
    endfunction

    function automatic void automaton_clear();
        n_states = 1; last_st = 0; slen[0] = 0; slink[0] = 0;
        row_empty(0);
        matcher_restart();
    endfunction

    function automatic bit text_extend(int c);
        int cur, p, q, cl;
        bit found;
        found = 0;
        if (slen[last_st] >= MAXT || n_states + 2 > NST) return 1;
        cur = n_states++;
        row_empty(cur);
        slen[cur] = slen[last_st] + 1;
        p = last_st;
        forever begin
            if (trans[p*ALPHA+c] != 0) begin
                found = 1;
                break;
            end
            trans[p*ALPHA+c] = cur;
            if (p == 0) break;
            p = slink[p];
        end
        if (!found) begin
            slink[cur] = 0;
        end else begin
            q = trans[p*ALPHA+c];
            if (slen[p] + 1 == slen[q]) begin
                slink[cur] = q;
            end else begin
                cl = n_states++;
                for (int i = 0; i < ALPHA; i++) trans[cl*ALPHA+i] = trans[q*ALPHA+i];
                slen[cl] = slen[p] + 1;
                slink[cl] = slink[q];
                forever begin
                    if (trans[p*ALPHA+c] != q) break;
                    trans[p*ALPHA+c] = cl;
                    if (p == 0) break;
                    p = slink[p];
                end
                slink[q] = cl;
                slink[cur] = cl;
            end
        end
        last_st = cur;
        return 0;
    endfunction

    function automatic void pattern_match(int c);
        int v, pos;
        v = m_state; pos = pat_pos;
        while (v != 0 && trans[v*ALPHA+c] == 0) begin
            v = slink[v];
            cur_len = slen[v];
        end
        if (trans[v*ALPHA+c] != 0) begin
            v = trans[v*ALPHA+c];
            cur_len++;
        end
        m_state = v;
        if (cur_len > best_len) begin
            best_len = cur_len;
            best_pos = pos;
        end
        if (pat_pos < POS_MAX) pat_pos++;
    endfunction

    function automatic lcs_res_t lcs_predict(mode_t md, logic [7:0] sym);
        lcs_res_t r;
        r = '0;
        case (md)
            MODE_CLEAR:   automaton_clear();
            MODE_EXTEND:  r.status = text_extend(int'(sym));
            MODE_RESTART: matcher_restart();
            default:      pattern_match(int'(sym));
        endcase
        r.states    = n_states[8:0];
        r.match_len = cur_len[8:0];
        r.best_len  = best_len[8:0];
        r.best_end  = best_pos[15:0];
        return r;
    endfunction

    task automatic send_beat(mode_t md, logic [7:0] sym);
        if (burst_left == 0) begin
            if ($urandom_range(0, 2) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, sym, md};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        lcs_q.push_back(lcs_predict(md, sym));
        @(negedge aclk);
    endtask

    task automatic wait_drain();
        while (lcs_q.size() != 0) @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else case ($urandom_range(0, 7))
            0, 1:    m_tready <= 1'b0;
            default: m_tready <= 1'b1;
        endcase
    end

    always @(posedge aclk) begin
        lcs_res_t got, exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            got = lcs_res_t'(m_tdata[43:0]);
            if (lcs_q.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected result beat %h", got);
            end else begin
                exp_r = lcs_q.pop_front();
                if (got !== exp_r) begin
                    n_err++;
                    if (n_err <= 10) begin
                        $write("mismatch: exp st%0d ml%0d bl%0d be%0d s%0d, ",
                               exp_r.states, exp_r.match_len, exp_r.best_len,
                               exp_r.best_end, exp_r.status);
                        $display("got st%0d ml%0d bl%0d be%0d s%0d",
                                 got.states, got.match_len, got.best_len,
                                 got.best_end, got.status);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) idle_cyc <= 0;
        else idle_cyc <= idle_cyc + 1;
        if (idle_cyc > WDOG) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic test_directed();
        send_beat(MODE_MATCH, 8'h00);
        send_beat(MODE_EXTEND, 8'h00);
        send_beat(MODE_EXTEND, 8'hFF);
        send_beat(MODE_EXTEND, 8'h00);
        send_beat(MODE_EXTEND, 8'h00);
        send_beat(MODE_EXTEND, 8'hFF);
        send_beat(MODE_EXTEND, 8'h00);
        send_beat(MODE_MATCH, 8'h00);
        send_beat(MODE_MATCH, 8'hFF);
        send_beat(MODE_MATCH, 8'h55);
        send_beat(MODE_MATCH, 8'h00);
        send_beat(MODE_EXTEND, 8'hAA);
        send_beat(MODE_MATCH, 8'hAA);
        send_beat(MODE_RESTART, 8'hFF);
        send_beat(MODE_MATCH, 8'hFF);
        send_beat(MODE_CLEAR, 8'h5A);
        send_beat(MODE_MATCH, 8'h00);
    endtask

    // fill the text store to its limit, then overflow
    task automatic test_full_store();
        send_beat(MODE_CLEAR, 8'h00);
        for (int i = 0; i < MAXT + 4; i++) send_beat(MODE_EXTEND, 8'($urandom_range(0, 3)));
        for (int i = 0; i < 40; i++) send_beat(MODE_MATCH, 8'($urandom_range(0, 3)));
    endtask

    // small alphabets give repeats, clones and long matches
    task automatic test_random(int n);
        int k, alpha_hi, tl;
        k = 0;
        while (k < n) begin
            alpha_hi = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(1, 3);
            send_beat(MODE_CLEAR, 8'($urandom));
            tl = $urandom_range(1, 40);
            for (int i = 0; i < tl; i++) send_beat(MODE_EXTEND, 8'($urandom_range(0, alpha_hi)));
            send_beat(MODE_RESTART, 8'($urandom));
            for (int i = 0; i < tl + 10; i++) begin
                case ($urandom_range(0, 19))
                    0:       send_beat(MODE_EXTEND, 8'($urandom_range(0, alpha_hi)));
                    1:       send_beat(MODE_MATCH, 8'($urandom));
                    2:       send_beat(MODE_RESTART, 8'($urandom));
                    default: send_beat(MODE_MATCH, 8'($urandom_range(0, alpha_hi)));
                endcase
            end
            k += 2 * tl + 12;
        end
    endtask

    initial begin
        automaton_clear();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_full_store();
        test_random(1100);
        s_tvalid <= 1'b0;
        wait_drain();
        repeat (600) @(negedge aclk);
        if (n_err == 0 && lcs_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: suffix_automaton_lcs_engine_core.f
sv/salcs_pkg.sv
sv/suffix_automaton_lcs_engine_core.sv
tb/suffix_automaton_lcs_engine_core_test.sv
